/* hdl/alid_pkg.sv */
// ---------------------------------------------------------------------------
// alid_pkg: shared definitions for the array list insert/delete unit
// Request and status codes, and the command and status bundles that pass
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package alid_pkg;

    // Default list capacity.
    localparam int DEFAULT_CAPACITY = 16;

    // Field widths of the request and result words.
    localparam int REQ_W   = 2;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int LCNT_W  = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_POS  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new request word
        logic read_k;    // read the entry at the request position
        logic shift_rd;  // read the neighbor of the cursor entry
        logic shift_wr;  // write the neighbor into the cursor entry
        logic place;     // write the new value at the request position
        logic finish;    // commit the count and load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_insert;
        logic is_read;
        logic is_clear;
        logic err;       // position or full error for the held request
        logic more;      // another entry still has to move
        logic out_free;  // the result register can take a word this cycle
    } stat_t;

endpackage

/* hdl/alid_ram.sv */
// ---------------------------------------------------------------------------
// alid_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when no read
// is issued.
// ---------------------------------------------------------------------------
module alid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/alid_ctrl.sv */
// ---------------------------------------------------------------------------
// alid_ctrl: request sequencer
// Steps one request at a time through checking, entry shifting, the final
// write and the hand-off to the result register.
// ---------------------------------------------------------------------------
module alid_ctrl
    import alid_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EVAL     = 3'd1;
    localparam logic [2:0] S_SHIFT_RD = 3'd2;
    localparam logic [2:0] S_SHIFT_WR = 3'd3;
    localparam logic [2:0] S_PLACE    = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.err || stat.is_clear)
                begin
                    state_next = S_DONE;
                end
                else if (stat.is_read)
                begin
                    cmd.read_k = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.more)
                begin
                    state_next = S_SHIFT_RD;
                end
                else if (stat.is_insert)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.shift_rd = 1'b1;
                state_next   = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_EVAL;
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/alid_datapath.sv */
// ---------------------------------------------------------------------------
// alid_datapath: list storage, count, cursor and result register
// Holds the request under work, moves entries one at a time through the
// entry RAM and builds the result word.
// ---------------------------------------------------------------------------
module alid_datapath
    import alid_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic [REQ_W-1:0]    in_req_type,
    input  logic [POS_W-1:0]    in_position,
    input  logic [VAL_W-1:0]    in_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STAT_W-1:0]   out_status,
    output logic [LCNT_W-1:0]   out_list_count,
    output logic [VAL_W-1:0]    out_read_value
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    // Request held while it is worked on.
    logic [REQ_W-1:0]  req_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     count_reg;

    // Result register.
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [LCNT_W-1:0] out_count_reg;
    logic [VAL_W-1:0]  out_value_reg;

    logic [PW-1:0]     pos_w;
    logic [PW-1:0]     cnt_w;
    logic [PW-1:0]     idx_w;
    logic [PW-1:0]     k_w;
    logic [STAT_W-1:0] status_code;
    logic [CW-1:0]     count_next;
    logic              is_insert;
    logic              is_delete;
    logic              is_read;
    logic              is_clear;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    assign is_insert = (req_reg == REQ_INSERT);
    assign is_delete = (req_reg == REQ_DELETE);
    assign is_read   = (req_reg == REQ_READ);
    assign is_clear  = (req_reg == REQ_CLEAR);

    assign pos_w = PW'(pos_reg);
    assign cnt_w = PW'(count_reg);
    assign idx_w = PW'(idx_reg);
    assign k_w   = pos_w - PW'(1);

    // Range and capacity checks for the held request.
    always_comb
    begin
        status_code = ST_OK;
        if (is_insert)
        begin
            if (pos_w == '0 || pos_w > cnt_w + PW'(1))
            begin
                status_code = ST_POS;
            end
            else if (cnt_w >= PW'(CAPACITY))
            begin
                status_code = ST_FULL;
            end
        end
        else if (is_delete || is_read)
        begin
            if (pos_w == '0 || pos_w > cnt_w)
            begin
                status_code = ST_POS;
            end
        end
    end

    // Count after the request commits.
    always_comb
    begin
        count_next = count_reg;
        if (is_clear)
        begin
            count_next = '0;
        end
        else if (status_code == ST_OK && is_insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (status_code == ST_OK && is_delete)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Status to the controller.
    always_comb
    begin
        stat.is_insert = is_insert;
        stat.is_read   = is_read;
        stat.is_clear  = is_clear;
        stat.err       = (status_code != ST_OK);
        stat.more      = is_insert ? (idx_w > k_w) : (idx_w + PW'(1) < cnt_w);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // RAM port selection: shifts move the neighbor into the cursor entry.
    always_comb
    begin
        ram_re    = cmd.shift_rd || cmd.read_k;
        ram_raddr = AW'(k_w);
        if (cmd.shift_rd)
        begin
            ram_raddr = is_insert ? AW'(idx_reg - CW'(1)) : AW'(idx_reg + CW'(1));
        end
        ram_we    = cmd.shift_wr || cmd.place;
        ram_waddr = cmd.place ? AW'(k_w) : AW'(idx_reg);
        ram_wdata = cmd.place ? val_reg : ram_rdata;
    end

    alid_ram #(
        .WIDTH(VAL_W),
        .DEPTH(CAPACITY),
        .AW   (AW)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Request capture and cursor.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_req_type;
            pos_reg <= in_position;
            val_reg <= in_value;
            if (in_req_type == REQ_INSERT)
            begin
                idx_reg <= count_reg;
            end
            else
            begin
                idx_reg <= CW'(in_position - POS_W'(1));
            end
        end
        else if (cmd.shift_wr)
        begin
            idx_reg <= is_insert ? idx_reg - CW'(1) : idx_reg + CW'(1);
        end
    end

    // Entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.finish)
        begin
            count_reg <= count_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status_reg <= status_code;
            out_count_reg  <= LCNT_W'(count_next);
            out_value_reg  <= (is_read && status_code == ST_OK) ? ram_rdata : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_list_count = out_count_reg;
    assign out_read_value = out_value_reg;

endmodule

/* hdl/array_list_insert_delete_unit.sv */
// ---------------------------------------------------------------------------
// array_list_insert_delete_unit: fixed-capacity list with positional edits
// Takes insert, delete, clear and read requests on the s_axis side and
// returns one status word per request on the m_axis side.
// ---------------------------------------------------------------------------
// Usage:
//   Each request word on s_axis gives exactly one result word on m_axis:
//   a status, the list length after the request and, for a good read, the
//   entry at the requested 1-based position.
//   Requests are handled one at a time; s_axis_tready is high only while
//   the unit waits for a new word.
//   After acceptance a request passes a check step; a clear, read or
//   rejected request then goes to the result stage. An insert moves
//   (length - position + 1) entries and then writes the new value; a
//   delete moves (length - position) entries. The entry RAM has one read
//   and one write port, so each moved entry costs a read, a write and a
//   check step. The result stage loads the result register once it is free.
//   The next word is accepted once the result register is loaded and the
//   unit is back in its idle state.
//   If the receiver stalls, the result stays in the output register and the
//   unit still accepts the next request; it holds that request's result
//   until the register is free.
//   Reset empties the list; the entry RAM itself is not cleared.
// ---------------------------------------------------------------------------
module array_list_insert_delete_unit
    import alid_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [1:0] req_type, [6:2] position, [38:7] value, [39] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] status, [6:2] list_count, [38:7] read_value, [39] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    cmd_t              cmd;
    stat_t             stat;
    logic [STAT_W-1:0] res_status;
    logic [LCNT_W-1:0] res_count;
    logic [VAL_W-1:0]  res_value;

    // Sequencer.
    alid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(s_axis_tvalid),
        .req_ready(s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and result datapath.
    alid_datapath #(
        .CAPACITY(CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_req_type   (s_axis_tdata[1:0]),
        .in_position   (s_axis_tdata[6:2]),
        .in_value      (s_axis_tdata[38:7]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_status    (res_status),
        .out_list_count(res_count),
        .out_read_value(res_value)
    );

    // Pack the result word.
    assign m_axis_tdata = {1'b0, res_value, res_count, res_status};

endmodule

/* verif/array_list_insert_delete_unit_tb.sv */
// ---------------------------------------------------------------------------
// array_list_insert_delete_unit_tb: self-checking bench for the list unit
// Sends a short table of directed requests (empty list, position limits,
// full list, clear) and then several hundred random requests shaped to grow
// and shrink the list. Typed script rows carry their own expected word;
// other words get theirs from a local model. Each m_axis result word is
// compared field by field with the oldest one. Both sides idle at random.
// ---------------------------------------------------------------------------
module array_list_insert_delete_unit_tb;
    import alid_pkg::*;

    localparam int LIST_CAP     = DEFAULT_CAPACITY;
    localparam int RANDOM_WORDS = 750;
    localparam int SCRIPT_LEN   = 28;
    localparam int SETTLE_CYCLES = 60;

    // One expected result word.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LCNT_W-1:0] count;
        logic [VAL_W-1:0]  rd;
    } list_result_t;

    // One row of the directed script; typed rows carry their own result.
    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
        logic [4:0]        rep;
        logic              typed;
        logic [STAT_W-1:0] status;
        logic [LCNT_W-1:0] count;
        logic [VAL_W-1:0]  rd;
    } script_row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [1:0] req_type, [6:2] position, [38:7] value, [39] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [1:0] status, [6:2] list_count, [38:7] read_value, [39] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Local copy of the list contents and length.
    logic [VAL_W-1:0] list_entries [LIST_CAP];
    int               list_len;

    list_result_t pending_results [$];
    int           mismatches = 0;
    bit           quiet = 1'b0;

    // Directed requests: empty list, limits, a fill to full, clear.
    script_row_t script [SCRIPT_LEN] = '{
        '{REQ_READ,   5'd1,  32'h0,        5'd1,  1'b1, ST_POS,  5'd0,  32'h0},
        '{REQ_DELETE, 5'd1,  32'h0,        5'd1,  1'b1, ST_POS,  5'd0,  32'h0},
        '{REQ_INSERT, 5'd0,  32'h12345678, 5'd1,  1'b1, ST_POS,  5'd0,  32'h0},
        '{REQ_INSERT, 5'd2,  32'h12345678, 5'd1,  1'b1, ST_POS,  5'd0,  32'h0},
        '{REQ_INSERT, 5'd1,  32'h7FFFFFFF, 5'd1,  1'b1, ST_OK,   5'd1,  32'h0},
        '{REQ_INSERT, 5'd2,  32'h80000000, 5'd1,  1'b1, ST_OK,   5'd2,  32'h0},
        '{REQ_INSERT, 5'd1,  32'hFFFFFFFF, 5'd1,  1'b1, ST_OK,   5'd3,  32'h0},
        '{REQ_INSERT, 5'd3,  32'h00000000, 5'd1,  1'b0, ST_OK,   5'd0,  32'h0},
        '{REQ_READ,   5'd4,  32'h0,        5'd1,  1'b0, ST_OK,   5'd0,  32'h0},
        '{REQ_READ,   5'd1,  32'h0,        5'd1,  1'b0, ST_OK,   5'd0,  32'h0},
        '{REQ_READ,   5'd5,  32'hFFFFFFFF, 5'd1,  1'b1, ST_POS,  5'd4,  32'h0},
        '{REQ_DELETE, 5'd31, 32'h0,        5'd1,  1'b1, ST_POS,  5'd4,  32'h0},
        '{REQ_DELETE, 5'd2,  32'h0,        5'd1,  1'b0, ST_OK,   5'd0,  32'h0},
        '{REQ_DELETE, 5'd3,  32'h0,        5'd1,  1'b0, ST_OK,   5'd0,  32'h0},
        '{REQ_INSERT, 5'd31, 32'hA5A5A5A5, 5'd1,  1'b1, ST_POS,  5'd2,  32'h0},
        '{REQ_INSERT, 5'd2,  32'h01234567, 5'd14, 1'b0, ST_OK,   5'd0,  32'h0},
        '{REQ_INSERT, 5'd17, 32'h5A5A5A5A, 5'd1,  1'b1, ST_FULL, 5'd16, 32'h0},
        '{REQ_INSERT, 5'd18, 32'h5A5A5A5A, 5'd1,  1'b1, ST_POS,  5'd16, 32'h0},
        '{REQ_READ,   5'd16, 32'h0,        5'd1,  1'b0, ST_OK,   5'd0,  32'h0},
        '{REQ_READ,   5'd0,  32'h0,        5'd1,  1'b1, ST_POS,  5'd16, 32'h0},
        '{REQ_DELETE, 5'd1,  32'h0,        5'd1,  1'b0, ST_OK,   5'd0,  32'h0},
        '{REQ_INSERT, 5'd16, 32'hCAFEF00D, 5'd1,  1'b0, ST_OK,   5'd0,  32'h0},
        '{REQ_DELETE, 5'd16, 32'h0,        5'd1,  1'b0, ST_OK,   5'd0,  32'h0},
        '{REQ_CLEAR,  5'd31, 32'hFFFFFFFF, 5'd1,  1'b1, ST_OK,   5'd0,  32'h0},
        '{REQ_READ,   5'd1,  32'h0,        5'd1,  1'b1, ST_POS,  5'd0,  32'h0},
        '{REQ_CLEAR,  5'd0,  32'h0,        5'd1,  1'b1, ST_OK,   5'd0,  32'h0},
        '{REQ_INSERT, 5'd1,  32'h55555555, 5'd1,  1'b1, ST_OK,   5'd1,  32'h0},
        '{REQ_READ,   5'd1,  32'h0,        5'd1,  1'b1, ST_OK,   5'd1,  32'h55555555}
    };

    array_list_insert_delete_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the unit hangs.
    initial
    begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

    // Applies one request to the local list and returns its result word.
    function automatic list_result_t apply_list_request(input logic [REQ_W-1:0] req,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic [VAL_W-1:0] val);
        list_result_t res;
        int           i;
        res = '0;
        res.status = ST_OK;
        case (req)
            REQ_INSERT:
            begin
                if (pos < 1 || pos > list_len + 1)
                    res.status = ST_POS;
                else if (list_len >= LIST_CAP)
                    res.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > pos - 1; i--)
                        list_entries[i] = list_entries[i-1];
                    list_entries[pos-1] = val;
                    list_len++;
                end
            end
            REQ_DELETE:
            begin
                if (pos < 1 || pos > list_len)
                    res.status = ST_POS;
                else
                begin
                    for (i = pos - 1; i + 1 < list_len; i++)
                        list_entries[i] = list_entries[i+1];
                    list_len--;
                end
            end
            REQ_CLEAR:
                list_len = 0;
            default:
            begin
                if (pos < 1 || pos > list_len)
                    res.status = ST_POS;
                else
                    res.rd = list_entries[pos-1];
            end
        endcase
        res.count = list_len[LCNT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Offers one request word, waits for the handshake and queues its result.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val, input bit typed,
                                input list_result_t typed_res);
        list_result_t res;
        while (!quiet && $urandom_range(0, 99) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, val, pos, req};
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = apply_list_request(req, pos, val);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // Holds off the sender until every queued result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // The receiver stalls at random outside the quiet stretch.
    always @(posedge clk)
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 11);

    // Compares each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", m_axis_tdata[31:0], '0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[1:0] !== want.status)
                    report_mismatch("status", 32'(m_axis_tdata[1:0]), 32'(want.status));
                if (m_axis_tdata[6:2] !== want.count)
                    report_mismatch("list_count", 32'(m_axis_tdata[6:2]),
                                    32'(want.count));
                if (m_axis_tdata[38:7] !== want.rd)
                    report_mismatch("read_value", m_axis_tdata[38:7], want.rd);
            end
        end
    end

    // Main stimulus: reset, directed script, random requests, drain.
    initial
    begin
        script_row_t      row;
        logic [REQ_W-1:0] req;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        int               k;
        int               m;
        int               roll;
        bit               grow;

        list_len = 0;
        for (k = 0; k < LIST_CAP; k++)
            list_entries[k] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        for (k = 0; k < SCRIPT_LEN; k++)
        begin
            row = script[k];
            for (m = 0; m < row.rep; m++)
                send_request(row.req, row.pos, row.val + m, row.typed,
                             list_result_t'{row.status, row.count, row.rd});
        end
        wait_for_results();

        // Random part: alternating grow and shrink phases with some noise.
        for (k = 0; k < RANDOM_WORDS; k++)
        begin
            quiet = (k >= 300 && k < 450);
            if (k == 500)
                wait_for_results();
            grow = ((k / 60) % 2) == 0;
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 15) == 0)
                case ($urandom_range(0, 3))
                    0: val = 32'h80000000;
                    1: val = 32'h7FFFFFFF;
                    2: val = 32'h00000000;
                    default: val = 32'hFFFFFFFF;
                endcase
            else
                val = $urandom;
            if (roll < 7)
            begin
                req = REQ_W'($urandom_range(0, 3));
                pos = POS_W'($urandom_range(0, 31));
            end
            else if (roll < 9)
            begin
                req = REQ_CLEAR;
                pos = POS_W'($urandom_range(0, 31));
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < (grow ? 60 : 20))
                    req = REQ_INSERT;
                else if (roll < (grow ? 75 : 70))
                    req = REQ_DELETE;
                else
                    req = REQ_READ;
                if (req == REQ_INSERT)
                    pos = POS_W'($urandom_range(1, list_len + 1));
                else if (list_len == 0)
                    pos = POS_W'(1);
                else
                    pos = POS_W'($urandom_range(1, list_len));
            end
            send_request(req, pos, val, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        quiet = 1'b0;

        // Let the last results come back, then allow for stray words.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/alid_pkg.sv
hdl/alid_ram.sv
hdl/alid_ctrl.sv
hdl/alid_datapath.sv
hdl/array_list_insert_delete_unit.sv
verif/array_list_insert_delete_unit_tb.sv
